FILE: hw/rtl/ptrf_pkg.sv
// ----------------------------------------------------------------------------
// ptrf_pkg
// Shared types and constants of the peer table and replay filter.
// ----------------------------------------------------------------------------
`default_nettype none

package ptrf_pkg;

  // Default number of peer slots
  localparam int PEER_SLOTS_DEFAULT = 8;

  // Field widths
  localparam int MAC_W  = 48;
  localparam int CAPS_W = 16;
  localparam int BOOT_W = 32;
  localparam int SEQ_W  = 32;
  localparam int SLOT_W = 3;

  // Stream widths
  localparam int IN_DATA_W  = 136;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 8;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_IS_LEADER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FOLLOWER_MASK   = 2'd1;
  localparam logic [CAPS_W-1:0]    FOLLOWER_MASK_RESET = 16'h0002;

  // Packet kinds
  localparam logic [1:0] OP_HELLO     = 2'd0;
  localparam logic [1:0] OP_SYNC_REQ  = 2'd1;
  localparam logic [1:0] OP_STATE     = 2'd2;
  localparam logic [1:0] OP_STATE_ACK = 2'd3;

  // Verdict codes
  localparam logic [1:0] VERDICT_ACCEPT  = 2'd0;
  localparam logic [1:0] VERDICT_NO_SLOT = 2'd1;
  localparam logic [1:0] VERDICT_UNKNOWN = 2'd2;
  localparam logic [1:0] VERDICT_STALE   = 2'd3;

  // Broadcast station address
  localparam logic [MAC_W-1:0] BCAST_MAC = {MAC_W{1'b1}};

  // Write command broadcast along the row of cells
  typedef struct packed {
    logic              en;
    logic              add;
    logic [MAC_W-1:0]  mac;
    logic              set_rc;
    logic              role;
    logic [CAPS_W-1:0] caps;
    logic              set_seq;
    logic [BOOT_W-1:0] boot;
    logic [SEQ_W-1:0]  seq;
    logic              set_reg;
  } cell_wr_t;

  // Entry contents that a selected cell drives out (zero when not selected)
  typedef struct packed {
    logic              registered;
    logic              has_seq;
    logic              role;
    logic [CAPS_W-1:0] caps;
    logic [BOOT_W-1:0] boot;
    logic [SEQ_W-1:0]  seq;
  } entry_view_t;

endpackage : ptrf_pkg

`default_nettype wire

FILE: hw/rtl/ptrf_cell.sv
// ----------------------------------------------------------------------------
// ptrf_cell
// One peer slot: holds the entry, matches the looked-up address and takes
// its place in the lowest-free-slot chain.
// ----------------------------------------------------------------------------
`default_nettype none

module ptrf_cell
  import ptrf_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [MAC_W-1:0] lk_mac,
  input  wire logic             free_in,
  output logic                  free_out,
  output logic                  first_free,
  output logic                  match,
  input  wire logic             sel,
  input  wire cell_wr_t         wr,
  output entry_view_t           view
);

  logic              active;
  logic              registered;
  logic              has_seq;
  logic [MAC_W-1:0]  mac;
  logic              role;
  logic [CAPS_W-1:0] caps;
  logic [BOOT_W-1:0] boot;
  logic [SEQ_W-1:0]  seq;

  // Match and pass the free mark on to the next cell
  assign match      = active && (mac == lk_mac);
  assign free_out   = free_in || !active;
  assign first_free = !active && !free_in;

  // Drive out the entry when selected
  always_comb begin
    view = '0;
    if (sel) begin
      view.registered = registered;
      view.has_seq    = has_seq;
      view.role       = role;
      view.caps       = caps;
      view.boot       = boot;
      view.seq        = seq;
    end
  end

  // Flags of the entry; an add loads has_seq and registered from set_seq and set_reg
  always_ff @(posedge clk) begin
    if (rst) begin
      active     <= 1'b0;
      registered <= 1'b0;
      has_seq    <= 1'b0;
    end else if (wr.en && sel) begin
      if (wr.add) begin
        active <= 1'b1;
      end
      if (wr.add || wr.set_seq) begin
        has_seq <= wr.set_seq;
      end
      if (wr.add || wr.set_reg) begin
        registered <= wr.set_reg;
      end
    end
  end

  // Payload of the entry
  always_ff @(posedge clk) begin
    if (wr.en && sel) begin
      if (wr.add) begin
        mac <= wr.mac;
      end
      if (wr.set_rc) begin
        role <= wr.role;
        caps <= wr.caps;
      end
      if (wr.set_seq) begin
        boot <= wr.boot;
        seq  <= wr.seq;
      end
    end
  end

endmodule : ptrf_cell

`default_nettype wire

FILE: hw/rtl/peer_table_replay_filter_top.sv
// Each accepted beat passes a lookup step, which registers the chosen slot,
// then an update of the cell row that loads its result beat into the output
// register, held back while the output beat stalls. A new packet is taken
// only once the previous one has been committed to the output register.
// Reset (synchronous, rst high): clears every slot's active, registered and
// sequence-held flags and loads local_is_leader = 0, follower mask = 2.
// ----------------------------------------------------------------------------
// peer_table_replay_filter_top
// Peer table with per-peer anti-replay sequence check, built as a row of
// identical slot cells.
// ----------------------------------------------------------------------------
`default_nettype none

module peer_table_replay_filter_top
  import ptrf_pkg::*;
#(
  parameter int PEER_SLOTS = PEER_SLOTS_DEFAULT
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // Configuration write port
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  // Packet stream in
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // src_mac[47:0], src_role[48], capabilities[64:49], boot_id[96:65],
  // sequence_req[128:97], has_content[129], zero[135:130]
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  // op[1:0]
  input  wire logic [IN_USER_W-1:0]  s_axis_tuser,
  // Verdict stream out
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // verdict[1:0], slot[4:2], send_state[5], apply_state[6], zero[7]
  output logic [OUT_DATA_W-1:0]      m_axis_tdata
);

  localparam int IDX_W = (PEER_SLOTS > 1) ? $clog2(PEER_SLOTS) : 1;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_LOOK = 3'b010,
    ST_UPD  = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  // Configuration registers
  logic              local_is_leader;
  logic [CAPS_W-1:0] follower_mask;

  // Held packet
  logic [1:0]        p_op;
  logic [MAC_W-1:0]  p_mac;
  logic              p_role;
  logic [CAPS_W-1:0] p_caps;
  logic [BOOT_W-1:0] p_boot;
  logic [SEQ_W-1:0]  p_seq;
  logic              p_content;

  // Lookup results
  logic [PEER_SLOTS-1:0] sel;
  logic [PEER_SLOTS-1:0] sel_next;
  logic                  found;
  logic                  found_next;
  logic                  is_add;
  logic                  is_add_next;
  logic [1:0]            fail_code;
  logic [1:0]            fail_code_next;

  // Cell row wiring
  logic [PEER_SLOTS:0]   free_ch;
  logic [PEER_SLOTS-1:0] first_free;
  logic [PEER_SLOTS-1:0] match;
  entry_view_t           views [PEER_SLOTS];
  entry_view_t           view;
  cell_wr_t              wr;

  // Result register
  logic             out_valid;
  logic [1:0]       r_verdict;
  logic [SLOT_W-1:0] r_slot;
  logic             r_send;
  logic             r_apply;

  logic             is_hs;
  logic             hit;
  logic             bcast;
  logic             ok;
  logic             role_new;
  logic [CAPS_W-1:0] caps_new;
  logic [IDX_W-1:0] idx;
  logic             out_free;
  logic             commit;

  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {1'b0, r_apply, r_send, r_slot, r_verdict};

  assign out_free = !out_valid || m_axis_tready;
  assign commit   = (state == ST_UPD) && out_free;

  // Configuration writes; other indexes are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      local_is_leader <= 1'b0;
      follower_mask   <= FOLLOWER_MASK_RESET;
    end else if (cfg_we) begin
      if (cfg_index == CFG_LOCAL_IS_LEADER) begin
        local_is_leader <= cfg_data[0];
      end else if (cfg_index == CFG_FOLLOWER_MASK) begin
        follower_mask <= cfg_data[CAPS_W-1:0];
      end
    end
  end

  // Capture the packet beat
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      p_op      <= s_axis_tuser;
      p_mac     <= s_axis_tdata[47:0];
      p_role    <= s_axis_tdata[48];
      p_caps    <= s_axis_tdata[64:49];
      p_boot    <= s_axis_tdata[96:65];
      p_seq     <= s_axis_tdata[128:97];
      p_content <= s_axis_tdata[129];
    end
  end

  // Row of slot cells with the lowest-free chain running through it
  assign free_ch[0] = 1'b0;

  for (genvar g = 0; g < PEER_SLOTS; g++) begin : g_cell
    ptrf_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .lk_mac     (p_mac),
      .free_in    (free_ch[g]),
      .free_out   (free_ch[g+1]),
      .first_free (first_free[g]),
      .match      (match[g]),
      .sel        (sel[g]),
      .wr         (wr),
      .view       (views[g])
    );
  end

  // Lookup: pick the matching slot, or the lowest free one for an add
  assign is_hs = (p_op == OP_HELLO) || (p_op == OP_SYNC_REQ);
  assign hit   = |match;
  assign bcast = (p_mac == BCAST_MAC);

  always_comb begin
    sel_next       = '0;
    found_next     = 1'b0;
    is_add_next    = 1'b0;
    fail_code_next = VERDICT_UNKNOWN;
    if (hit) begin
      sel_next   = match;
      found_next = 1'b1;
    end else if (is_hs) begin
      fail_code_next = VERDICT_NO_SLOT;
      if (!bcast && free_ch[PEER_SLOTS]) begin
        sel_next    = first_free;
        found_next  = 1'b1;
        is_add_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_LOOK) begin
      sel       <= sel_next;
      found     <= found_next;
      is_add    <= is_add_next;
      fail_code <= fail_code_next;
    end
  end

  // Gather the selected entry and encode its slot number
  always_comb begin
    view = '0;
    idx  = '0;
    for (int i = 0; i < PEER_SLOTS; i++) begin
      view = view | views[i];
      if (sel[i]) begin
        idx = idx | IDX_W'(i);
      end
    end
  end

  // Replay check and new role and capabilities
  assign ok = is_add || !view.has_seq || (p_boot != view.boot) || (p_seq > view.seq);

  always_comb begin
    if (p_op == OP_HELLO) begin
      role_new = p_role;
      caps_new = p_caps;
    end else if (is_add) begin
      role_new = 1'b1;
      caps_new = follower_mask;
    end else begin
      role_new = view.role;
      caps_new = view.caps;
    end
  end

  // Write command to the row
  always_comb begin
    wr         = '0;
    wr.en      = commit && found;
    wr.add     = is_add;
    wr.mac     = p_mac;
    wr.set_rc  = (p_op == OP_HELLO) || is_add;
    wr.role    = role_new;
    wr.caps    = caps_new;
    wr.set_seq = ok;
    wr.boot    = p_boot;
    wr.seq     = p_seq;
    wr.set_reg = ok && is_hs;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      if (!found) begin
        r_verdict <= fail_code;
      end else if (!ok) begin
        r_verdict <= VERDICT_STALE;
      end else begin
        r_verdict <= VERDICT_ACCEPT;
      end
      r_slot  <= found ? SLOT_W'(idx) : '0;
      r_send  <= found && ok && is_hs && local_is_leader && role_new &&
                 ((caps_new & follower_mask) != '0);
      r_apply <= found && ok && (p_op == OP_STATE) && !local_is_leader && p_content;
    end
  end

  // Sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_next = ST_LOOK;
        end
      end
      ST_LOOK: begin
        state_next = ST_UPD;
      end
      ST_UPD: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule : peer_table_replay_filter_top

`default_nettype wire
